// ===== rtl/core/rse_pkg.sv =====
// rse_pkg: token codes, status codes and shared types for the rpn stack evaluator
// used by rse_alu and rpn_stack_evaluator_unit; depends on nothing
`timescale 1ns / 1ps

package rse_pkg;

   localparam int DataWidth = 32;
   localparam int DivSteps  = 32;

   typedef enum logic [2:0] {
      TOK_PUSH = 3'd0,
      TOK_ADD  = 3'd1,
      TOK_SUB  = 3'd2,
      TOK_MUL  = 3'd3,
      TOK_DIV  = 3'd4
   } token_op_type;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_UNDER = 2'd1;
   localparam logic [1:0] ST_OVER  = 2'd2;
   localparam logic [1:0] ST_DIVZ  = 2'd3;

   typedef struct packed {
      logic       start;
      logic [2:0] op;
   } alu_req_type;

   typedef struct packed {
      logic                 done;
      logic [DataWidth-1:0] result;
   } alu_rsp_type;

   // keeps the first error of an expression
   function automatic logic [1:0] first_error(logic [1:0] cur, logic [1:0] code);
      first_error = (cur == ST_OK) ? code : cur;
   endfunction

endpackage

// ===== rtl/core/rse_req_if.sv =====
// rse_req_if: token channel (valid/ready plus token payload)
// no dependencies
`timescale 1ns / 1ps

interface rse_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         op;
   logic signed [31:0] operand;
   logic               last_token;

   modport source (output valid, output op, output operand, output last_token, input ready);
   modport sink   (input valid, input op, input operand, input last_token, output ready);
endinterface

// ===== rtl/core/rse_rsp_if.sv =====
// rse_rsp_if: result channel (valid/ready plus value and status)
// no dependencies
`timescale 1ns / 1ps

interface rse_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] value;
   logic [1:0]         status;

   modport source (output valid, output value, output status, input ready);
   modport sink   (input valid, input value, input status, output ready);
endinterface

// ===== rtl/core/rpn_stack_evaluator_unit.sv =====
// rpn_stack_evaluator_unit: top level, token sequencer, stack memory and result register
// depends on rse_pkg, rse_req_if, rse_rsp_if and rse_alu
`timescale 1ns / 1ps

// Evaluates a reverse Polish expression one token word at a time and takes one
// token at a time. A push is written in the idle state. For add, subtract and multiply
// the two operands come out of the single-read-port stack memory one after the other,
// then the shared unit's registered result is written back. A divide by a nonzero value
// runs the shared unit's 32 shift-subtract steps between operand load and sign fix-up;
// a divide by zero skips them. A token marked last passes S_FIN_RD and S_FIN to read the
// top of the stack into the result register, and waits there while an earlier result
// word has not been taken. The result register lets the next token in while the result
// waits. The stack holds STACK_DEPTH entries and needs no clearing after reset.

module rpn_stack_evaluator_unit import rse_pkg::*; #(
   parameter int STACK_DEPTH = 64
) (
   input  logic     clock,
   input  logic     reset,
   rse_req_if.sink   req_if,
   rse_rsp_if.source rsp_if
);

   localparam int CntW = $clog2(STACK_DEPTH + 1);
   localparam int IdxW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   typedef enum logic [2:0] {
      S_IDLE, S_RD_B, S_RD_A, S_EXEC, S_WAIT, S_FIN_RD, S_FIN
   } seq_state_type;

   seq_state_type        state_ff, state_in;
   logic [CntW-1:0]      count_ff, count_in;
   logic [1:0]           err_ff, err_in;
   logic [2:0]           op_ff, op_in;
   logic                 last_ff, last_in;
   logic [DataWidth-1:0] b_ff, b_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DataWidth-1:0] rsp_value_ff, rsp_value_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;

   logic [DataWidth-1:0] stack_mem [STACK_DEPTH];
   logic [DataWidth-1:0] rd_data_ff;
   logic [IdxW-1:0]      rd_idx;
   logic                 wr_en;
   logic [IdxW-1:0]      wr_idx;
   logic [DataWidth-1:0] wr_data;

   logic [CntW-1:0]      cnt_m1, cnt_m2;
   logic                 full;
   alu_req_type          alu_req;
   alu_rsp_type          alu_rsp;

   assign cnt_m1 = count_ff - CntW'(1);
   assign cnt_m2 = count_ff - CntW'(2);
   assign full   = (count_ff >= CntW'(STACK_DEPTH));
   assign rd_idx = (state_ff == S_RD_A) ? cnt_m2[IdxW-1:0] : cnt_m1[IdxW-1:0];

   rse_alu u_alu (
      .clock   (clock),
      .reset   (reset),
      .alu_req (alu_req),
      .a       (rd_data_ff),
      .b       (b_ff),
      .alu_rsp (alu_rsp)
   );

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_idx] <= wr_data;
      end
      rd_data_ff <= stack_mem[rd_idx];
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      err_in        = err_ff;
      op_in         = op_ff;
      last_in       = last_ff;
      b_in          = b_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_idx        = count_ff[IdxW-1:0];
      wr_data       = req_if.operand;
      alu_req       = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               op_in    = req_if.op;
               last_in  = req_if.last_token;
               state_in = req_if.last_token ? S_FIN_RD : S_IDLE;
               case (req_if.op)
                  TOK_PUSH: begin
                     if (full) begin
                        err_in = first_error(err_ff, ST_OVER);
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CntW'(1);
                     end
                  end
                  TOK_ADD, TOK_SUB, TOK_MUL, TOK_DIV: begin
                     if (count_ff < CntW'(2)) begin
                        err_in = first_error(err_ff, ST_UNDER);
                     end else begin
                        state_in = S_RD_B;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_RD_B: state_in = S_RD_A;
         S_RD_A: begin
            b_in     = rd_data_ff;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            // rd_data_ff now holds the left operand a, the entry below the top; b_ff holds the top
            alu_req.start = 1'b1;
            alu_req.op    = op_ff;
            state_in      = S_WAIT;
         end
         S_WAIT: begin
            if (alu_rsp.done) begin
               wr_en    = 1'b1;
               wr_idx   = cnt_m2[IdxW-1:0];
               wr_data  = alu_rsp.result;
               count_in = cnt_m1;
               if (op_ff == TOK_DIV && b_ff == '0) begin
                  err_in = first_error(err_ff, ST_DIVZ);
               end
               state_in = last_ff ? S_FIN_RD : S_IDLE;
            end
         end
         S_FIN_RD: state_in = S_FIN;
         S_FIN: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               if (count_ff == '0) begin
                  rsp_value_in  = '0;
                  rsp_status_in = first_error(err_ff, ST_UNDER);
               end else begin
                  rsp_value_in  = rd_data_ff;
                  rsp_status_in = err_ff;
               end
               count_in = '0;
               err_in   = ST_OK;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         err_ff       <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      last_ff       <= last_in;
      b_ff          <= b_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_if.ready  = (state_ff == S_IDLE);
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.value  = rsp_value_ff;
   assign rsp_if.status = rsp_status_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_alu_done_in_wait : assert property (@(posedge clock) disable iff (reset)
      alu_rsp.done |-> state_ff == S_WAIT)
      else $error("alu result outside wait state");

   a_rsp_from_fin : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FIN))
      else $error("result word raised outside finish state");

   a_rsp_clears_stack : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> count_ff == '0 && err_ff == ST_OK)
      else $error("stack not emptied after result");

endmodule

// ===== rtl/core/rse_alu.sv =====
// rse_alu: shared arithmetic unit, registered add/sub/mul, signed divide
// by restoring shift-subtract, one quotient bit per cycle; depends on rse_pkg
`timescale 1ns / 1ps

module rse_alu import rse_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  alu_req_type          alu_req,
   input  logic [DataWidth-1:0] a,
   input  logic [DataWidth-1:0] b,
   output alu_rsp_type          alu_rsp
);

   localparam int StepW = $clog2(DivSteps);

   typedef enum logic [1:0] {A_IDLE, A_DIV, A_FIX} alu_state_type;

   alu_state_type        state_ff, state_in;
   logic [StepW-1:0]     step_ff, step_in;
   logic [DataWidth-1:0] rem_ff, rem_in;
   logic [DataWidth-1:0] quo_ff, quo_in;
   logic [DataWidth-1:0] dvs_ff, dvs_in;
   logic                 neg_ff, neg_in;
   logic [DataWidth-1:0] result_ff, result_in;
   logic                 done_ff, done_in;

   logic [DataWidth:0]   rem_shift;
   logic [DataWidth:0]   rem_diff;
   logic [DataWidth-1:0] mag_a, mag_b;

   assign mag_a     = a[DataWidth-1] ? (~a + 1'b1) : a;
   assign mag_b     = b[DataWidth-1] ? (~b + 1'b1) : b;
   assign rem_shift = {rem_ff, quo_ff[DataWidth-1]};
   assign rem_diff  = rem_shift - {1'b0, dvs_ff};

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dvs_in    = dvs_ff;
      neg_in    = neg_ff;
      result_in = result_ff;
      done_in   = 1'b0;
      case (state_ff)
         A_IDLE: begin
            if (alu_req.start) begin
               case (alu_req.op)
                  TOK_ADD: begin
                     result_in = a + b;
                     done_in   = 1'b1;
                  end
                  TOK_SUB: begin
                     result_in = a - b;
                     done_in   = 1'b1;
                  end
                  TOK_MUL: begin
                     result_in = a * b;
                     done_in   = 1'b1;
                  end
                  TOK_DIV: begin
                     if (b == '0) begin
                        result_in = '0;
                        done_in   = 1'b1;
                     end else begin
                        rem_in   = '0;
                        quo_in   = mag_a;
                        dvs_in   = mag_b;
                        neg_in   = a[DataWidth-1] ^ b[DataWidth-1];
                        step_in  = '0;
                        state_in = A_DIV;
                     end
                  end
                  default: begin
                     result_in = '0;
                     done_in   = 1'b1;
                  end
               endcase
            end
         end
         A_DIV: begin
            // dividend shifts out of quo as quotient bits shift in
            if (!rem_diff[DataWidth]) begin
               rem_in = rem_diff[DataWidth-1:0];
               quo_in = {quo_ff[DataWidth-2:0], 1'b1};
            end else begin
               rem_in = rem_shift[DataWidth-1:0];
               quo_in = {quo_ff[DataWidth-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == StepW'(DivSteps - 1)) begin
               state_in = A_FIX;
            end
         end
         A_FIX: begin
            result_in = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
            done_in   = 1'b1;
            state_in  = A_IDLE;
         end
         default: state_in = A_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      step_ff   <= step_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      dvs_ff    <= dvs_in;
      neg_ff    <= neg_in;
      result_ff <= result_in;
   end

   assign alu_rsp.done   = done_ff;
   assign alu_rsp.result = result_ff;

endmodule

// ===== tb/rse_eval_checker.sv =====
// rse_eval_checker: tracks the token stream, evaluates each expression and checks result words
// depends on rse_pkg, rse_req_if and rse_rsp_if
`timescale 1ns / 1ps

module rse_eval_checker import rse_pkg::*; #(
   parameter int STACK_DEPTH = 64
) (
   input  logic clock,
   input  logic reset,
   rse_req_if   req_if,
   rse_rsp_if   rsp_if,
   output int   mismatch_count,
   output int   results_owed
);

   typedef struct {
      logic [31:0] value;
      logic [1:0]  status;
   } eval_result_type;

   logic [31:0]     eval_stack [STACK_DEPTH];
   int unsigned     eval_depth;
   logic [1:0]      eval_error;
   eval_result_type owed_results [$];

   function automatic void note_error(input logic [1:0] code);
      if (eval_error == ST_OK) eval_error = code;
   endfunction

   function automatic logic [31:0] quotient_toward_zero(input logic [31:0] num,
                                                        input logic [31:0] den);
      logic [31:0] num_mag;
      logic [31:0] den_mag;
      logic [31:0] quo;
      num_mag = num[31] ? 32'd0 - num : num;
      den_mag = den[31] ? 32'd0 - den : den;
      quo = num_mag / den_mag;
      return (num[31] ^ den[31]) ? 32'd0 - quo : quo;
   endfunction

   task automatic evaluate_token(input logic [2:0] op, input logic [31:0] operand,
                                 input logic last_token);
      logic [31:0]     lhs;
      logic [31:0]     rhs;
      logic [31:0]     folded;
      eval_result_type res;
      case (op)
         TOK_PUSH: begin
            if (eval_depth >= STACK_DEPTH) begin
               note_error(ST_OVER);
            end else begin
               eval_stack[eval_depth] = operand;
               eval_depth++;
            end
         end
         TOK_ADD, TOK_SUB, TOK_MUL, TOK_DIV: begin
            if (eval_depth < 2) begin
               note_error(ST_UNDER);
            end else begin
               rhs = eval_stack[eval_depth - 1];
               lhs = eval_stack[eval_depth - 2];
               case (op)
                  TOK_ADD: folded = lhs + rhs;
                  TOK_SUB: folded = lhs - rhs;
                  TOK_MUL: folded = lhs * rhs;
                  default: begin
                     if (rhs == 32'd0) begin
                        note_error(ST_DIVZ);
                        folded = 32'd0;
                     end else begin
                        folded = quotient_toward_zero(lhs, rhs);
                     end
                  end
               endcase
               eval_depth--;
               eval_stack[eval_depth - 1] = folded;
            end
         end
         default: ;   // unused codes leave the stack alone
      endcase
      if (last_token) begin
         if (eval_depth == 0) begin
            note_error(ST_UNDER);
            res.value = 32'd0;
         end else begin
            res.value = eval_stack[eval_depth - 1];
         end
         res.status = eval_error;
         owed_results.push_back(res);
         eval_depth = 0;
         eval_error = ST_OK;
      end
   endtask

   always @(posedge clock) begin
      eval_result_type want;
      if (reset) begin
         eval_depth     = 0;
         eval_error     = ST_OK;
         mismatch_count = 0;
         owed_results.delete();
      end else begin
         if (req_if.valid && req_if.ready)
            evaluate_token(req_if.op, req_if.operand, req_if.last_token);
         if (rsp_if.valid && rsp_if.ready) begin
            if (owed_results.size() == 0) begin
               $error("result word with no expression pending: value %h status %0d",
                      rsp_if.value, rsp_if.status);
               mismatch_count++;
            end else begin
               want = owed_results.pop_front();
               if (rsp_if.value !== want.value) begin
                  $error("value: expected %h, got %h", want.value, rsp_if.value);
                  mismatch_count++;
               end
               if (rsp_if.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_if.status);
                  mismatch_count++;
               end
            end
         end
      end
      results_owed = owed_results.size();
   end

endmodule

// ===== tb/tb_rpn_stack_evaluator_unit.sv =====
// tb_rpn_stack_evaluator_unit: token stimulus, result back-pressure and verdict
// depends on rse_pkg, rse_req_if, rse_rsp_if, rse_eval_checker and rpn_stack_evaluator_unit
`timescale 1ns / 1ps

module tb_rpn_stack_evaluator_unit;
   import rse_pkg::*;

   localparam int StackDepth = 64;
   localparam int LongHold   = 300;
   localparam int DrainWait  = 80;

   logic clock;
   logic reset;
   int   mismatch_count;
   int   results_owed;
   int   token_count;
   int   send_idle_pct;
   int   stall_pct;
   int   hold_left;
   logic hold_req;
   logic hold_ack;

   rse_req_if req_if ();
   rse_rsp_if rsp_if ();

   rpn_stack_evaluator_unit #(.STACK_DEPTH(StackDepth)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   rse_eval_checker #(.STACK_DEPTH(StackDepth)) eval_checker (
      .clock          (clock),
      .reset          (reset),
      .req_if         (req_if),
      .rsp_if         (rsp_if),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tb_rpn_stack_evaluator_unit: FAIL");
      $finish;
   end

   // receiver: random stalls, plus a long hold-off each time hold_req toggles
   initial begin
      rsp_if.ready = 1'b0;
      hold_left    = 0;
      hold_ack     = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req != hold_ack) begin
            hold_ack     <= hold_req;
            hold_left    <= LongHold;
            rsp_if.ready <= 1'b0;
         end else if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left    <= hold_left - 1;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   function automatic logic [31:0] pick_operand();
      logic [31:0] corners [5];
      corners = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
      case ($urandom_range(7))
         0:       return corners[$urandom_range(4)];
         1, 2:    return 32'($urandom_range(16)) - 32'd8;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [2:0] pick_operator();
      token_op_type ops [4];
      ops = '{TOK_ADD, TOK_SUB, TOK_MUL, TOK_DIV};
      return ops[$urandom_range(3)];
   endfunction

   task automatic send_token(input logic [2:0] op, input logic [31:0] operand,
                             input logic last_token);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.op         <= op;
      req_if.operand    <= operand;
      req_if.last_token <= last_token;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      if (last_token || op <= TOK_DIV) token_count++;
   endtask

   // well-formed postfix expression over a given number of operands
   task automatic send_expression(input int operands);
      int depth;
      int pushed;
      depth  = 0;
      pushed = 0;
      while (pushed < operands || depth > 1) begin
         if (pushed < operands && (depth < 2 || $urandom_range(1))) begin
            send_token(TOK_PUSH, pick_operand(), operands == 1);
            pushed++;
            depth++;
         end else begin
            send_token(pick_operator(), $urandom, pushed == operands && depth == 2);
            depth--;
         end
      end
   endtask

   task automatic settle();
      req_if.valid <= 1'b0;
      // let the checker log the last accepted word before counting
      @(posedge clock);
      wait (results_owed == 0);
      @(posedge clock);
   endtask

   initial begin
      int phase;
      int target;
      int pick;
      int run;
      req_if.valid      = 1'b0;
      req_if.op         = TOK_PUSH;
      req_if.operand    = '0;
      req_if.last_token = 1'b0;
      hold_req          = 1'b0;
      send_idle_pct     = 0;
      stall_pct         = 0;
      token_count       = 0;
      reset             = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // last word on an empty stack
      send_token(TOK_ADD, 32'h0, 1'b1);
      // add wraps
      send_token(TOK_PUSH, 32'h7FFF_FFFF, 1'b0);
      send_token(TOK_PUSH, 32'h0000_0001, 1'b0);
      send_token(TOK_ADD, 32'h0, 1'b1);
      // most negative over minus one
      send_token(TOK_PUSH, 32'h8000_0000, 1'b0);
      send_token(TOK_PUSH, 32'hFFFF_FFFF, 1'b0);
      send_token(TOK_DIV, 32'h0, 1'b1);
      // multiply keeps the low half
      send_token(TOK_PUSH, 32'h0001_0000, 1'b0);
      send_token(TOK_PUSH, 32'h0001_0000, 1'b0);
      send_token(TOK_MUL, 32'h0, 1'b1);
      // divide by zero, then a subtract on its zero result; the error must stay
      send_token(TOK_PUSH, 32'd5, 1'b0);
      send_token(TOK_PUSH, 32'd0, 1'b0);
      send_token(TOK_DIV, 32'h0, 1'b0);
      send_token(TOK_PUSH, 32'hFFFF_FFF9, 1'b0);
      send_token(TOK_SUB, 32'h0, 1'b1);
      // unused code still honors the last mark
      send_token(TOK_PUSH, 32'd9, 1'b0);
      send_token(3'd7, 32'hFFFF_FFFF, 1'b1);
      // underflow first, then divide by zero stays behind it
      send_token(TOK_PUSH, 32'd4, 1'b0);
      send_token(TOK_SUB, 32'h0, 1'b0);
      send_token(TOK_PUSH, 32'd0, 1'b0);
      send_token(TOK_DIV, 32'h0, 1'b1);
      // negative dividend, quotient rounds toward zero
      send_token(TOK_PUSH, 32'hFFFF_FFF9, 1'b0);
      send_token(TOK_PUSH, 32'd2, 1'b0);
      send_token(TOK_DIV, 32'h0, 1'b1);
      settle();

      // receiver holds off while short expressions keep coming
      hold_req <= ~hold_req;
      repeat (12) send_expression(2);
      settle();

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 61; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 61; end
            default: begin send_idle_pct = 20; stall_pct = 20; end
         endcase
         target = token_count + 290;
         while (token_count < target) begin
            pick = $urandom_range(99);
            if (pick < 78) begin
               send_expression(($urandom_range(9) == 0) ? $urandom_range(7, 14)
                                                         : $urandom_range(1, 5));
            end else if (pick < 79) begin
               // deep run that may spill past the stack
               run = $urandom_range(StackDepth - 4, StackDepth + 6);
               for (int k = 1; k <= run; k++)
                  send_token(TOK_PUSH, pick_operand(), k == run);
            end else begin
               send_token(3'($urandom_range(7)), pick_operand(), $urandom_range(4) == 0);
            end
         end
         // sender pauses until the block has caught up
         settle();
      end

      req_if.valid <= 1'b0;
      wait (results_owed == 0);
      repeat (DrainWait) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_rpn_stack_evaluator_unit: PASS");
      end else begin
         $display("tb_rpn_stack_evaluator_unit: FAIL");
      end
      $finish;
   end

endmodule

// ===== rpn_stack_evaluator_unit.f =====
rtl/core/rse_pkg.sv
rtl/core/rse_req_if.sv
rtl/core/rse_rsp_if.sv
rtl/core/rse_alu.sv
rtl/core/rpn_stack_evaluator_unit.sv
tb/rse_eval_checker.sv
tb/tb_rpn_stack_evaluator_unit.sv
